>>> hw/rtl/brle_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and widths for the RLE8 bitmap run decoder.
package brle_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int POS_W       = 13;
    localparam int DIM_W       = 14;
    localparam int CFG_IDX_W   = 1;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [POS_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [POS_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [7:0] ESC_END_OF_LINE   = 8'd0;
    localparam logic [7:0] ESC_END_OF_BITMAP = 8'd1;
    localparam logic [7:0] ESC_DELTA         = 8'd2;

    typedef enum logic [2:0] {
        PH_COUNT   = 3'd0,
        PH_VALUE   = 3'd1,
        PH_ESCAPE  = 3'd2,
        PH_DELTA_X = 3'd3,
        PH_DELTA_Y = 3'd4,
        PH_LITERAL = 3'd5,
        PH_PAD     = 3'd6,
        PH_DONE    = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SPAN      = 2'd0,
        KIND_ROW_END   = 2'd1,
        KIND_IMAGE_END = 2'd2
    } t_kind;

    typedef struct packed {
        t_phase           phase;
        logic [7:0]       run_count;
        logic [7:0]       literal_left;
        logic             pad_pending;
        logic [7:0]       delta_columns;
        logic [POS_W-1:0] cur_column;
        logic [POS_W-1:0] cur_row;
    } t_state;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic [7:0]       pixel_value;
        logic [7:0]       span_length;
        logic             overrun;
    } t_result;

    localparam t_state STATE_CLEAR = '{
        phase:         PH_COUNT,
        run_count:     8'd0,
        literal_left:  8'd0,
        pad_pending:   1'b0,
        delta_columns: 8'd0,
        cur_column:    '0,
        cur_row:       '0
    };

    // Saturating position add: 13-bit position plus 8-bit step.
    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [7:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {{(POS_W-7){1'b0}}, b};
        return s[POS_W] ? POS_MAX : s[POS_W-1:0];
    endfunction

endpackage

>>> hw/rtl/brle_decode.sv
`timescale 1ns / 1ps
// Single-pass decode of one compressed byte: next decoder state and the result item.
module brle_decode #(
    parameter int MAX_DIM = brle_pkg::MAX_DIM_DEF
) (
    input  brle_pkg::t_state                 i_state,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_start_of_image,
    input  logic [brle_pkg::POS_W-1:0]       i_image_width,
    input  logic [brle_pkg::POS_W-1:0]       i_image_height,
    output brle_pkg::t_state                 o_next_state,
    output brle_pkg::t_result                o_result
);

    localparam logic [brle_pkg::DIM_W-1:0] DIM_CAP = brle_pkg::DIM_W'(MAX_DIM);

    brle_pkg::t_state            cur;
    logic [brle_pkg::DIM_W-1:0]  width_cap;
    logic [brle_pkg::DIM_W-1:0]  height_cap;
    logic [brle_pkg::DIM_W-1:0]  span_end;
    logic [7:0]                  literal_dec;

    // A start-of-image item decodes from a cleared state.
    assign cur = i_start_of_image ? brle_pkg::STATE_CLEAR : i_state;

    assign width_cap  = ({1'b0, i_image_width} > DIM_CAP) ? DIM_CAP : {1'b0, i_image_width};
    assign height_cap = ({1'b0, i_image_height} > DIM_CAP) ? DIM_CAP
                                                           : {1'b0, i_image_height};
    assign literal_dec = cur.literal_left - 8'd1;

    // Next state.
    always_comb begin
        o_next_state = cur;
        case (cur.phase)
            brle_pkg::PH_COUNT: begin
                if (i_data_byte != 8'd0) begin
                    o_next_state.run_count = i_data_byte;
                    o_next_state.phase     = brle_pkg::PH_VALUE;
                end else begin
                    o_next_state.phase = brle_pkg::PH_ESCAPE;
                end
            end
            brle_pkg::PH_VALUE: begin
                o_next_state.cur_column = brle_pkg::sat_add(cur.cur_column, cur.run_count);
                o_next_state.run_count  = 8'd0;
                o_next_state.phase      = brle_pkg::PH_COUNT;
            end
            brle_pkg::PH_ESCAPE: begin
                if (i_data_byte == brle_pkg::ESC_END_OF_LINE) begin
                    o_next_state.cur_column = '0;
                    o_next_state.cur_row    = brle_pkg::sat_add(cur.cur_row, 8'd1);
                    o_next_state.phase      = brle_pkg::PH_COUNT;
                end else if (i_data_byte == brle_pkg::ESC_END_OF_BITMAP) begin
                    o_next_state.phase = brle_pkg::PH_DONE;
                end else if (i_data_byte == brle_pkg::ESC_DELTA) begin
                    o_next_state.phase = brle_pkg::PH_DELTA_X;
                end else begin
                    o_next_state.literal_left = i_data_byte;
                    o_next_state.pad_pending  = i_data_byte[0];
                    o_next_state.phase        = brle_pkg::PH_LITERAL;
                end
            end
            brle_pkg::PH_DELTA_X: begin
                o_next_state.delta_columns = i_data_byte;
                o_next_state.phase         = brle_pkg::PH_DELTA_Y;
            end
            brle_pkg::PH_DELTA_Y: begin
                o_next_state.cur_column    = brle_pkg::sat_add(cur.cur_column,
                                                               cur.delta_columns);
                o_next_state.cur_row       = brle_pkg::sat_add(cur.cur_row, i_data_byte);
                o_next_state.delta_columns = 8'd0;
                o_next_state.phase         = brle_pkg::PH_COUNT;
            end
            brle_pkg::PH_LITERAL: begin
                o_next_state.cur_column   = brle_pkg::sat_add(cur.cur_column, 8'd1);
                o_next_state.literal_left = literal_dec;
                if (literal_dec == 8'd0) begin
                    o_next_state.phase       = cur.pad_pending ? brle_pkg::PH_PAD
                                                               : brle_pkg::PH_COUNT;
                    o_next_state.pad_pending = 1'b0;
                end
            end
            brle_pkg::PH_PAD: begin
                o_next_state.phase = brle_pkg::PH_COUNT;
            end
            default: begin
                // Image finished: bytes are swallowed until the next start of image.
                o_next_state = cur;
            end
        endcase
    end

    // Result item.
    always_comb begin
        o_result             = '0;
        o_result.kind        = brle_pkg::KIND_SPAN;
        o_result.column      = cur.cur_column;
        o_result.row         = cur.cur_row;
        case (cur.phase)
            brle_pkg::PH_VALUE: begin
                o_result.valid       = 1'b1;
                o_result.pixel_value = i_data_byte;
                o_result.span_length = cur.run_count;
            end
            brle_pkg::PH_LITERAL: begin
                o_result.valid       = 1'b1;
                o_result.pixel_value = i_data_byte;
                o_result.span_length = 8'd1;
            end
            brle_pkg::PH_ESCAPE: begin
                if (i_data_byte == brle_pkg::ESC_END_OF_LINE) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = brle_pkg::KIND_ROW_END;
                end else if (i_data_byte == brle_pkg::ESC_END_OF_BITMAP) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = brle_pkg::KIND_IMAGE_END;
                end
            end
            default: begin
                o_result.valid = 1'b0;
            end
        endcase
        span_end = {1'b0, cur.cur_column} + {{(brle_pkg::DIM_W-8){1'b0}}, o_result.span_length};
        if (o_result.kind == brle_pkg::KIND_SPAN) begin
            o_result.overrun = ({1'b0, cur.cur_row} >= height_cap) || (span_end > width_cap);
        end
    end

endmodule

>>> hw/rtl/bmp_rle8_run_decoder.sv
`timescale 1ns / 1ps
// Top level of the RLE8 bitmap run decoder: input register, decode, result register.
//
// Accepts one compressed byte per clock cycle unless the input side is stalled, and
// returns at most one result item per byte (a pixel span, a row-end marker or an
// image-end marker): the byte is held in an input register, decoded by a single pass of
// combinational logic against the decoder state, and the result is held in an
// output register. Both registers advance together whenever the output register is
// empty or being taken, so the sustained rate is one byte per cycle; a stall on the
// result side holds one byte in the input register before the input side stalls.
// The image width and height registers may be written only while the block is idle.
module bmp_rle8_run_decoder #(
    parameter int MAX_DIM = brle_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_start_of_image,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_kind,
    output logic [brle_pkg::POS_W-1:0]         o_column,
    output logic [brle_pkg::POS_W-1:0]         o_row,
    output logic [7:0]                         o_pixel_value,
    output logic [7:0]                         o_span_length,
    output logic                               o_overrun,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [brle_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [brle_pkg::POS_W-1:0]         i_cfg_data
);

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_in_soi;
    brle_pkg::t_state             r_state;
    brle_pkg::t_state             n_state;
    brle_pkg::t_result            n_result;
    logic                         r_out_valid;
    brle_pkg::t_kind              r_out_kind;
    logic [brle_pkg::POS_W-1:0]   r_out_column;
    logic [brle_pkg::POS_W-1:0]   r_out_row;
    logic [7:0]                   r_out_value;
    logic [7:0]                   r_out_length;
    logic                         r_out_overrun;
    logic [brle_pkg::POS_W-1:0]   r_image_width;
    logic [brle_pkg::POS_W-1:0]   r_image_height;
    logic                         out_free;
    logic                         advance;
    logic                         in_accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    brle_decode #(
        .MAX_DIM (MAX_DIM)
    ) u_decode (
        .i_state          (r_state),
        .i_data_byte      (r_in_byte),
        .i_start_of_image (r_in_soi),
        .i_image_width    (r_image_width),
        .i_image_height   (r_image_height),
        .o_next_state     (n_state),
        .o_result         (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= brle_pkg::WIDTH_RESET;
            r_image_height <= brle_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                brle_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                brle_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: begin
                    r_image_width <= r_image_width;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= brle_pkg::STATE_CLEAR;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= n_result.valid;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_soi  <= i_start_of_image;
        end
        if (advance) begin
            r_out_kind    <= n_result.kind;
            r_out_column  <= n_result.column;
            r_out_row     <= n_result.row;
            r_out_value   <= n_result.pixel_value;
            r_out_length  <= n_result.span_length;
            r_out_overrun <= n_result.overrun;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_column      = r_out_column;
    assign o_row         = r_out_row;
    assign o_pixel_value = r_out_value;
    assign o_span_length = r_out_length;
    assign o_overrun     = r_out_overrun;

    // An image-end marker leaves the decoder parked until the next start of image.
    a_image_end_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_result.valid && n_result.kind == brle_pkg::KIND_IMAGE_END)
        |=> (r_state.phase == brle_pkg::PH_DONE))
        else $error("decoder not parked after image end");

    // Markers carry no length and are never flagged.
    a_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != brle_pkg::KIND_SPAN)
        |-> (r_out_length == 8'd0 && !r_out_overrun))
        else $error("marker with length or overrun");

    // A pending pad byte only exists while literal bytes are still being taken.
    a_pad_in_literal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pad_pending |-> (r_state.phase == brle_pkg::PH_LITERAL))
        else $error("pad pending outside literal phase");

    // The decoder state is not moved while the input side is stalled.
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_state) || $past(!i_out_stall))
        else $error("decoder state moved while stalled");

endmodule
